/* hw/rtl/grid_line_of_sight_check_macros.svh */
// Assertion helpers shared by the RTL of the line-of-sight block.
// In synthesis builds the macros expand to nothing.
`ifndef GRID_LINE_OF_SIGHT_CHECK_MACROS_SVH
`define GRID_LINE_OF_SIGHT_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define GLOS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid_line_of_sight_check: assertion failed");

// Next-cycle implication, checked out of reset.
`define GLOS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid_line_of_sight_check: assertion failed");

`else

`define GLOS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define GLOS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/glos_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package glos_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int ROW_BYTES_MAX = (MAX_WIDTH + 31) / 32 * 4;
    localparam int BITMAP_DEPTH  = ROW_BYTES_MAX * MAX_HEIGHT;
    localparam int MEM_ADDR_W    = $clog2(BITMAP_DEPTH);

    // Fixed field widths of the transactions.
    localparam int BYTE_ADDR_W = 13;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int CFG_INDEX_W = 1;

    // Largest byte address the cell arithmetic can produce:
    // 255 * 64 + 31 fits in 16 bits.
    localparam int FULL_ADDR_W = 16;
    localparam int ROW_BYTES_W = 7;

    // Input tdata layout, lowest bit first.
    localparam int F_ADDR_LSB  = 0;
    localparam int F_VALUE_LSB = F_ADDR_LSB + BYTE_ADDR_W;
    localparam int F_SX_LSB    = F_VALUE_LSB + BYTE_W;
    localparam int F_SY_LSB    = F_SX_LSB + COORD_W;
    localparam int F_EX_LSB    = F_SY_LSB + COORD_W;
    localparam int F_EY_LSB    = F_EX_LSB + COORD_W;
    localparam int F_END       = F_EY_LSB + COORD_W;
    localparam int S_TDATA_W   = (F_END + 7) / 8 * 8;
    localparam int M_TDATA_W   = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] MAP_DIM_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } query_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } cell_issue_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } eval_status_t;

endpackage

`default_nettype wire

/* hw/rtl/glos_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module glos_ram #(
    parameter int  DATA_W = 8,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/glos_cell_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module glos_cell_eval (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  glos_pkg::cell_issue_t                 issue,
    input  glos_pkg::query_t                      query,
    input  logic [glos_pkg::DIM_W-1:0]            map_width,
    input  logic [glos_pkg::DIM_W-1:0]            map_height,
    output logic                                  rd_en,
    output logic [glos_pkg::MEM_ADDR_W-1:0]       rd_addr,
    input  logic [glos_pkg::BYTE_W-1:0]           rd_data,
    output glos_pkg::eval_status_t                status
);

    import glos_pkg::*;

    // Stage 0: cell geometry and bitmap address, read issued.
    logic signed [COORD_W:0]   dx, dy, qx, qy;
    logic                      endpoint, vert, horiz, force_on, need_cmp;
    logic [DIM_W:0]            w_sum;
    logic [ROW_BYTES_W-1:0]    row_bytes;
    logic [FULL_ADDR_W-1:0]    full_addr;
    logic                      in_map;

    assign dx = $signed({1'b0, query.ex}) - $signed({1'b0, query.sx});
    assign dy = $signed({1'b0, query.ey}) - $signed({1'b0, query.sy});
    assign qx = $signed({1'b0, issue.x}) - $signed({1'b0, query.sx});
    assign qy = $signed({1'b0, issue.y}) - $signed({1'b0, query.sy});

    assign endpoint = ((issue.x == query.sx) && (issue.y == query.sy))
                   || ((issue.x == query.ex) && (issue.y == query.ey));
    assign vert  = (dx == '0);
    assign horiz = (dy == '0);

    assign force_on = endpoint
                   || (vert && (issue.x == query.ex))
                   || (!vert && horiz && (issue.y == query.ey));
    // Off both axes of the start, and in the quadrant the line runs through.
    assign need_cmp = !endpoint && !vert && !horiz
                   && (qx != '0) && (qy != '0)
                   && ((dx[COORD_W] ^ dy[COORD_W]) == (qx[COORD_W] ^ qy[COORD_W]));

    // Rows are padded to whole 32-bit words.
    assign w_sum     = {1'b0, map_width} + (DIM_W + 1)'(31);
    assign row_bytes = {w_sum[DIM_W:5], 2'b00};
    assign full_addr = FULL_ADDR_W'(issue.y) * FULL_ADDR_W'(row_bytes)
                     + FULL_ADDR_W'(issue.x[COORD_W-1:3]);
    assign in_map = ({1'b0, issue.x} < map_width) && ({1'b0, issue.y} < map_height)
                 && (32'(full_addr) < 32'(BITMAP_DEPTH));

    assign rd_en   = issue.valid;
    assign rd_addr = MEM_ADDR_W'(full_addr);

    logic                    s1_valid_reg, s1_force_reg, s1_cmp_reg, s1_in_map_reg;
    logic signed [COORD_W:0] s1_qx_reg, s1_qy_reg;
    logic [2:0]              s1_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue.valid;
        end
        s1_force_reg  <= force_on;
        s1_cmp_reg    <= need_cmp;
        s1_in_map_reg <= in_map;
        s1_qx_reg     <= qx;
        s1_qy_reg     <= qy;
        s1_bit_reg    <= issue.x[2:0];
    end

    // Stage 1: bitmap bit, the two cross-product terms and dx*qx.
    logic [2:0]                    bit_sel;
    logic                          blocked;
    logic signed [2*COORD_W+1:0]   p_a, p_b, p_c;

    assign bit_sel = 3'd7 - s1_bit_reg;
    assign blocked = !s1_in_map_reg || !rd_data[bit_sel];
    assign p_a = (2*COORD_W+2)'(dy) * (2*COORD_W+2)'(s1_qx_reg);
    assign p_b = (2*COORD_W+2)'(s1_qy_reg) * (2*COORD_W+2)'(dx);
    assign p_c = (2*COORD_W+2)'(dx) * (2*COORD_W+2)'(s1_qx_reg);

    logic                        s2_valid_reg, s2_force_reg, s2_cmp_reg, s2_blocked_reg;
    logic signed [2*COORD_W+1:0] s2_pa_reg, s2_pb_reg, s2_pc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_force_reg   <= s1_force_reg;
        s2_cmp_reg     <= s1_cmp_reg;
        s2_blocked_reg <= blocked;
        s2_pa_reg      <= p_a;
        s2_pb_reg      <= p_b;
        s2_pc_reg      <= p_c;
    end

    // Stage 2: ten times the cross-product error against |dx*qx|.
    logic signed [2*COORD_W+2:0] diff;
    logic [2*COORD_W+1:0]        abs_diff;
    logic [2*COORD_W:0]          abs_c;
    logic [2*COORD_W+5:0]        tenfold;
    logic                        on_line;

    assign diff     = (2*COORD_W+3)'(s2_pa_reg) - (2*COORD_W+3)'(s2_pb_reg);
    assign abs_diff = diff[2*COORD_W+2] ? (2*COORD_W+2)'(-diff) : diff[2*COORD_W+1:0];
    assign abs_c    = s2_pc_reg[2*COORD_W+1] ? (2*COORD_W+1)'(-s2_pc_reg)
                                             : s2_pc_reg[2*COORD_W:0];
    assign tenfold  = ((2*COORD_W+6)'(abs_diff) << 3) + ((2*COORD_W+6)'(abs_diff) << 1);
    assign on_line  = s2_force_reg || (s2_cmp_reg && (tenfold <= (2*COORD_W+6)'(abs_c)));

    assign status.hit  = s2_valid_reg && on_line && s2_blocked_reg;
    assign status.busy = s1_valid_reg || s2_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/glos_scan_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "grid_line_of_sight_check_macros.svh"

module glos_scan_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_op,
    input  glos_pkg::query_t        s_query,
    output glos_pkg::query_t        query,
    output glos_pkg::cell_issue_t   issue,
    input  glos_pkg::eval_status_t  status,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    m_line_clear
);

    import glos_pkg::*;

    scan_state_t        state_reg, state_next;
    query_t             query_reg;
    logic [COORD_W-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0] x_lo_in, x_hi_in, y_lo_in, y_hi_in;
    logic               fail_reg;
    logic               out_valid_reg, out_valid_next, out_clear_reg;
    logic               q_accept, row_end, scan_last, out_load;
    logic               issue_valid;

    assign q_accept  = s_tvalid && s_tready && (s_op == OP_QUERY);
    assign row_end   = (x_reg == x_hi_reg);
    assign scan_last = row_end && (y_reg == y_hi_reg);

    assign x_lo_in = (s_query.sx < s_query.ex) ? s_query.sx : s_query.ex;
    assign x_hi_in = (s_query.sx < s_query.ex) ? s_query.ex : s_query.sx;
    assign y_lo_in = (s_query.sy < s_query.ey) ? s_query.sy : s_query.ey;
    assign y_hi_in = (s_query.sy < s_query.ey) ? s_query.ey : s_query.sy;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!status.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        issue_valid = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
                issue_valid = 1'b1;
            end
            ST_FLUSH: begin
                s_tready = 1'b0;
            end
            ST_DONE: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Row-major walk of the bounding box.
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (q_accept) begin
            x_next = x_lo_in;
            y_next = y_lo_in;
        end else if (state_reg == ST_SCAN) begin
            if (row_end) begin
                x_next = x_lo_reg;
                y_next = y_reg + COORD_W'(1);
            end else begin
                x_next = x_reg + COORD_W'(1);
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fail_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (q_accept) begin
                fail_reg <= 1'b0;
            end else if (status.hit) begin
                fail_reg <= 1'b1;
            end
        end
        x_reg <= x_next;
        y_reg <= y_next;
        if (q_accept) begin
            query_reg <= s_query;
            x_lo_reg  <= x_lo_in;
            x_hi_reg  <= x_hi_in;
            y_lo_reg  <= y_lo_in;
            y_hi_reg  <= y_hi_in;
        end
        if (out_load) begin
            out_clear_reg <= !fail_reg;
        end
    end

    assign query        = query_reg;
    assign issue.valid  = issue_valid;
    assign issue.x      = x_reg;
    assign issue.y      = y_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_line_clear = out_clear_reg;

    `GLOS_ASSERT_IMPLIES(a_no_accept_while_busy, aclk, aresetn, status.busy, !s_tready)
    `GLOS_ASSERT_NEXT(a_query_starts_scan, aclk, aresetn, q_accept, state_reg == ST_SCAN)
    `GLOS_ASSERT_IMPLIES(a_scan_in_box, aclk, aresetn, state_reg == ST_SCAN, (x_reg >= x_lo_reg) && (x_reg <= x_hi_reg) && (y_reg >= y_lo_reg) && (y_reg <= y_hi_reg))
    `GLOS_ASSERT_IMPLIES(a_result_after_done, aclk, aresetn, $rose(out_valid_reg), $past(state_reg) == ST_DONE)

endmodule

`default_nettype wire

/* hw/rtl/grid_line_of_sight_check.sv */
`timescale 1ns / 1ps
`default_nettype none

// Line-of-sight check over a 1-bit walkability bitmap held in an 8192-byte
// on-chip RAM. A transaction with tuser set to 0 writes one bitmap byte and
// returns nothing; cell (x, y) sits in byte y * row_bytes + x / 8, with
// row_bytes = ceil(map_width / 32) * 4, MSB first, and a set bit means
// walkable. A transaction with tuser set to 1 asks whether the straight line
// between two cells is clear and returns one transaction whose bit 0 is 1
// only if both endpoints and every cell of the bounding box that lies on the
// line (within a tenth of its slope) are walkable; cells outside map_width
// by map_height count as blocked. A query visits its bounding box one cell
// per cycle, since each cell costs one read of the bitmap RAM, then drains
// the pipeline and hands off its result. One query is in flight at a time;
// the result sits in an output register, so the next transaction is taken
// while it waits. Map width and height are to be written through the
// configuration port only while the block is idle; the user must keep to
// this, as the block itself does not enforce it. Bitmap bytes that were
// never written read as undefined.

module grid_line_of_sight_check (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [glos_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [glos_pkg::DIM_W-1:0]        cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // byte_address[12:0], byte_value[20:13], start_x[28:21], start_y[36:29],
    // end_x[44:37], end_y[52:45], zero fill above
    input  logic [glos_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[0]
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // line_clear[0], zero fill above
    output logic [glos_pkg::M_TDATA_W-1:0]    m_tdata
);

    import glos_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0] map_width_reg, map_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_DIM_RESET;
            map_height_reg <= MAP_DIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default: begin
                    map_width_reg <= map_width_reg;
                end
            endcase
        end
    end

    // Fields of the input transaction.
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]      byte_value;
    query_t                 s_query;

    assign byte_address = s_tdata[F_ADDR_LSB +: BYTE_ADDR_W];
    assign byte_value   = s_tdata[F_VALUE_LSB +: BYTE_W];
    assign s_query.sx   = s_tdata[F_SX_LSB +: COORD_W];
    assign s_query.sy   = s_tdata[F_SY_LSB +: COORD_W];
    assign s_query.ex   = s_tdata[F_EX_LSB +: COORD_W];
    assign s_query.ey   = s_tdata[F_EY_LSB +: COORD_W];

    // Bitmap writes go straight to the RAM in the accepting cycle. Queries
    // only read, and never overlap a write since the block is then busy.
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [MEM_ADDR_W-1:0] ram_rd_addr;
    logic [BYTE_W-1:0]     ram_rd_data;

    assign ram_wr_en = s_tvalid && s_tready && (s_tuser == OP_WRITE)
                    && (32'(byte_address) < 32'(BITMAP_DEPTH));

    glos_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (BITMAP_DEPTH)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (MEM_ADDR_W'(byte_address)),
        .wr_data (byte_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    query_t       query;
    cell_issue_t  issue;
    eval_status_t status;
    logic         line_clear;

    glos_scan_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_tuser),
        .s_query      (s_query),
        .query        (query),
        .issue        (issue),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_line_clear (line_clear)
    );

    glos_cell_eval u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (issue),
        .query      (query),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .rd_en      (ram_rd_en),
        .rd_addr    (ram_rd_addr),
        .rd_data    (ram_rd_data),
        .status     (status)
    );

    assign m_tdata = {(M_TDATA_W - 1)'(0), line_clear};

endmodule

`default_nettype wire

/* tb/grid_line_of_sight_check_tb.sv */
`timescale 1ns / 1ps

module grid_line_of_sight_check_tb;

    import glos_pkg::*;

    // After the last expected result, a trailing write may still be landing,
    // so this many quiet cycles are plenty.
    localparam int DRAIN_CYCLES = 16;
    // Well over ten times the slowest run this stimulus can produce.
    localparam int RUN_LIMIT_NS = 8_000_000;
    // Length of the stretch in which the result side refuses everything.
    localparam int HOLD_OFF_CYCLES = 400;

    // Mirror of the bitmap and of the map size registers. It predicts
    // line_clear for every accepted query and checks the results in order.
    class sight_board;
        bit [7:0]    bitmap [BITMAP_DEPTH];
        int unsigned map_w;
        int unsigned map_h;
        bit          pending_clear [$];
        int          errors;
        int          writes;
        int          queries;
        int          clear_seen;

        function new();
            map_w = 256;
            map_h = 256;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        // Cells outside the map are blocked; so is any cell whose byte would
        // fall beyond the store.
        function bit cell_open(int x, int y);
            int row_bytes;
            int addr;
            if (x < 0 || y < 0 || x >= map_w || y >= map_h)
                return 1'b0;
            row_bytes = (map_w + 31) / 32 * 4;
            addr = y * row_bytes + x / 8;
            if (addr >= BITMAP_DEPTH)
                return 1'b0;
            return bitmap[addr][7 - (x % 8)];
        endfunction

        // A cell is on the line if it is an endpoint, sits in the column of a
        // vertical line or the row of a horizontal one, or lies in the same
        // quadrant as the far end with a slope within a tenth of the line's.
        function bit on_line(int px, int py, int sx, int sy, int ex, int ey);
            int dx;
            int dy;
            int qx;
            int qy;
            int cross_err;
            int run;
            dx = ex - sx;
            dy = ey - sy;
            qx = px - sx;
            qy = py - sy;
            if ((px == sx && py == sy) || (px == ex && py == ey))
                return 1'b1;
            if (dx == 0)
                return px == ex;
            if (dy == 0)
                return py == ey;
            if (qx == 0 || qy == 0)
                return 1'b0;
            // All four are nonzero here, so comparing signs is enough.
            if (((dx < 0) != (dy < 0)) != ((qx < 0) != (qy < 0)))
                return 1'b0;
            cross_err = dy * qx - qy * dx;
            run = dx * qx;
            return 10 * (cross_err < 0 ? -cross_err : cross_err) <= (run < 0 ? -run : run);
        endfunction

        function bit predict_line_clear(int sx, int sy, int ex, int ey);
            if (!cell_open(sx, sy) || !cell_open(ex, ey))
                return 1'b0;
            for (int i = (sx < ex ? sx : ex); i <= (sx < ex ? ex : sx); i++) begin
                for (int j = (sy < ey ? sy : ey); j <= (sy < ey ? ey : sy); j++) begin
                    if (on_line(i, j, sx, sy, ex, ey) && !cell_open(i, j))
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_transaction(logic op, logic [S_TDATA_W-1:0] d);
            if (op == OP_WRITE) begin
                bitmap[d[F_ADDR_LSB +: BYTE_ADDR_W]] = d[F_VALUE_LSB +: BYTE_W];
                writes++;
            end else begin
                pending_clear.push_back(predict_line_clear(
                    d[F_SX_LSB +: COORD_W], d[F_SY_LSB +: COORD_W],
                    d[F_EX_LSB +: COORD_W], d[F_EY_LSB +: COORD_W]));
                queries++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            bit want;
            if (pending_clear.size() == 0) begin
                flag($sformatf("result transaction with no query waiting, m_tdata=%h", d));
                return;
            end
            want = pending_clear.pop_front();
            if (d[0] !== want)
                flag($sformatf("line_clear expected %0b, got %b", want, d[0]));
            else if (want)
                clear_seen++;
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    sight_board board;
    // Bytes the stimulus has already sent a write for.
    bit         loaded [BITMAP_DEPTH];
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         rx_hold_cycles;
    int         input_stall_cycles;
    int         map_settings;

    grid_line_of_sight_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Result side. Normally it stalls at random at the current rate; when a
    // hold-off is requested it keeps tready low until the hold-off runs out,
    // counting it down itself, so the block has to back up into its input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Both channels are sampled at the clock edge, before the drivers'
    // nonblocking updates land, so every transaction is seen exactly once.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (s_tvalid && s_tready)
                board.note_transaction(s_tuser, s_tdata);
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
        end
    end

    // Offers one input transaction, after a random gap at the current idle
    // rate, and returns at the edge where it is accepted. tvalid stays high
    // on return so back-to-back transactions follow without a gap.
    task automatic send_item(input logic op, input int addr, input int val,
                             input int sx, input int sy, input int ex, input int ey);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[F_ADDR_LSB +: BYTE_ADDR_W] = BYTE_ADDR_W'(addr);
        d[F_VALUE_LSB +: BYTE_W]     = BYTE_W'(val);
        d[F_SX_LSB +: COORD_W]       = COORD_W'(sx);
        d[F_SY_LSB +: COORD_W]       = COORD_W'(sy);
        d[F_EX_LSB +: COORD_W]       = COORD_W'(ex);
        d[F_EY_LSB +: COORD_W]       = COORD_W'(ey);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // The fields a transaction does not use still carry random bits.
    task automatic write_byte(input int addr, input int val);
        if (addr >= 0 && addr < BITMAP_DEPTH)
            loaded[addr] = 1'b1;
        send_item(OP_WRITE, addr, val, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255));
    endtask

    // A query may only look at bytes that were written. Any on-line cell
    // inside the current map whose byte is still unwritten gets a byte that
    // is mostly walkable before the query goes out.
    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        int row_bytes;
        int addr;
        row_bytes = (board.map_w + 31) / 32 * 4;
        for (int i = (sx < ex ? sx : ex); i <= (sx < ex ? ex : sx); i++) begin
            for (int j = (sy < ey ? sy : ey); j <= (sy < ey ? ey : sy); j++) begin
                if (i < board.map_w && j < board.map_h
                        && board.on_line(i, j, sx, sy, ex, ey)) begin
                    addr = j * row_bytes + i / 8;
                    if (addr < BITMAP_DEPTH && !loaded[addr])
                        write_byte(addr, ($urandom_range(99) < 80) ? 8'hFF
                                                                 : $urandom_range(255));
                end
            end
        end
    endtask

    task automatic ask_line(input int sx, input int sy, input int ex, input int ey);
        load_line(sx, sy, ex, ey);
        send_item(OP_QUERY, $urandom_range(BITMAP_DEPTH - 1), $urandom_range(255),
                  sx, sy, ex, ey);
    endtask

    // Only called while the block is idle. The enable stays high across both
    // register writes and is dropped once, after both.
    task automatic set_map_size(input int w, input int h);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAP_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_MAP_HEIGHT;
        cfg_data  <= DIM_W'(h);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.map_w = w;
        board.map_h = h;
        map_settings++;
    endtask

    // Stops offering, waits for every predicted result, then lets a trailing
    // write drain out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_clear.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int clamp_coord(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    // Random traffic shaped like real use: a few bitmap edits, mostly inside
    // the current map and mostly knocking single cells out, then a query.
    // Most queries stay within the map and span a few cells so the scan
    // reaches the slope test often; some run anywhere, some are long, and
    // some are forced vertical or horizontal.
    task automatic random_mix(input int n_queries, input int max_span);
        int row_bytes;
        int n_writes;
        int addr;
        int val;
        int span;
        int sx;
        int sy;
        int ex;
        int ey;
        for (int q = 0; q < n_queries; q++) begin
            row_bytes = (board.map_w + 31) / 32 * 4;
            n_writes = $urandom_range(2);
            for (int w = 0; w < n_writes; w++) begin
                if ($urandom_range(3) == 0)
                    addr = $urandom_range(BITMAP_DEPTH - 1);
                else
                    addr = $urandom_range(board.map_h - 1) * row_bytes
                         + $urandom_range(board.map_w - 1) / 8;
                case ($urandom_range(4))
                    0:       val = $urandom_range(255);
                    1:       val = 8'hFF;
                    default: val = 8'hFF ^ (1 << $urandom_range(7));
                endcase
                write_byte(addr, val);
            end
            span = ($urandom_range(9) == 0) ? 4 * max_span : max_span;
            if ($urandom_range(6) == 0) begin
                sx = $urandom_range(255);
                sy = $urandom_range(255);
            end else begin
                sx = $urandom_range(board.map_w - 1);
                sy = $urandom_range(board.map_h - 1);
            end
            ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
            case ($urandom_range(5))
                0:       ex = sx;
                1:       ey = sy;
                default: ;
            endcase
            ask_line(sx, sy, ex, ey);
        end
    endtask

    initial begin
        board = new();
        tx_idle_pct = 34;
        rx_idle_pct = 88;
        rx_hold_cycles = 0;
        input_stall_cycles = 0;
        map_settings = 0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_MAP_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_WRITE;
        s_tdata   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First phase: slow-ish sender, very reluctant receiver, full map.
        // Only bytes that a query can reach are written, each before the
        // query that needs it.
        set_map_size(256, 256);

        // Directed corner: a start cell that is blocked.
        write_byte(0, 8'h00);
        ask_line(0, 0, 0, 0);
        // A small patch with only cell (1,1) blocked.
        write_byte(0, 8'hFF);
        write_byte(32, 8'hBF);
        write_byte(64, 8'hFF);
        ask_line(0, 0, 2, 2);    // diagonal through the blocked cell
        ask_line(2, 2, 0, 0);    // same line walked backwards
        ask_line(0, 0, 2, 1);    // blocked cell in the box but off the line
        ask_line(0, 0, 1, 1);    // blocked end cell
        ask_line(0, 0, 0, 2);    // clear vertical line
        ask_line(1, 0, 1, 2);    // vertical line through the blocked cell
        ask_line(0, 1, 7, 1);    // horizontal line through the blocked cell
        ask_line(2, 1, 7, 1);    // clear horizontal line
        // The last byte of the store, at the far corner of the map.
        write_byte(BITMAP_DEPTH - 1, 8'hFF);
        ask_line(255, 255, 248, 255);
        ask_line(255, 255, 255, 255);
        settle();

        // A small map, so random lines often leave it.
        set_map_size(16, 6);
        random_mix(8, 4);
        settle();

        // Second phase: the sender mostly idles, the receiver rarely does.
        // A one-cell map puts almost everything out of bounds.
        tx_idle_pct = 88;
        rx_idle_pct = 34;
        set_map_size(1, 1);
        ask_line(0, 0, 0, 0);
        ask_line(1, 0, 0, 0);
        ask_line(0, 0, 0, 3);
        // Full-length lines: the largest scan the block can be asked for,
        // and a whole row.
        ask_line(0, 0, 255, 255);
        ask_line(255, 0, 0, 0);
        random_mix(3, 3);
        settle();

        // A width just past a row-stride step, with a short map.
        set_map_size(33, 6);
        random_mix(6, 6);
        settle();

        // Last phase: no idling on either side, a random map size, and one
        // long hold-off on the result side while queries keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_map_size($urandom_range(1, 24), $urandom_range(1, 8));
        random_mix(3, 8);
        rx_hold_cycles = HOLD_OFF_CYCLES;
        random_mix(8, 4);
        settle();

        $display("Covered %0d bitmap writes and %0d line queries (%0d clear) over %0d map sizes.",
                 board.writes, board.queries, board.clear_seen, map_settings);
        $display("Input was held back for %0d offered cycles; %0d result errors counted.",
                 input_stall_cycles, board.errors);
        if (board.errors == 0 && board.pending_clear.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT_NS;
        $display("Timed out with %0d results still expected.", board.pending_clear.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* grid_line_of_sight_check.f */
+incdir+hw/rtl
hw/rtl/glos_pkg.sv
hw/rtl/glos_ram.sv
hw/rtl/glos_cell_eval.sv
hw/rtl/glos_scan_ctrl.sv
hw/rtl/grid_line_of_sight_check.sv
tb/grid_line_of_sight_check_tb.sv
